[rtl/core/d2q9fc_pkg.sv]
// ----------------------------------------------------------------------------
// d2q9fc_pkg
// Shared widths, constants, lattice directions and types for the forced
// D2Q9 collision node.
// ----------------------------------------------------------------------------
`default_nettype none

package d2q9fc_pkg;

    // fixed point and field widths
    localparam int FRAC_BITS = 16;
    localparam int POP_W     = 18;
    localparam int FRC_W     = 17;
    localparam int VEL_W     = 17;
    localparam int RHO_W     = 17;
    localparam int RATE_W    = 17;
    localparam int NDIR      = 9;
    localparam int RATE_RESET = 81920;

    // word layout, padded to whole bytes
    localparam int IN_BITS  = NDIR * POP_W + 2 * FRC_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = NDIR * POP_W + RHO_W + 2 * VEL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // limits
    localparam int POP_MAX = (1 << (POP_W - 1)) - 1;
    localparam int POP_MIN = -(1 << (POP_W - 1));
    localparam int RHO_MAX = (1 << RHO_W) - 1;
    localparam int VEL_LIM = 1 << (VEL_W - 1);
    localparam int VEL_MAX = VEL_LIM - 1;
    localparam int ONE_Q   = 1 << FRAC_BITS;

    // moments and velocity divider
    localparam int SUM_W   = POP_W + 4;
    localparam int NUM_W   = POP_W + 5;
    localparam int MAG_W   = NUM_W - 1;
    localparam int QBITS   = VEL_W;
    localparam int DIVN_W  = MAG_W + FRAC_BITS + 1;
    localparam int DIVD_W  = RHO_W + 1;
    localparam int DIV_LAT = QBITS + 1;

    // shared products
    localparam int PROD_W = VEL_W + FRC_W;
    localparam int UV_W   = 2 * VEL_W + 1;
    localparam int UF_W   = PROD_W + 2 - FRAC_BITS;

    // lane depth
    localparam int LANE_LAT = 8;

    // lattice weights rounded to nearest
    localparam int WGT_W  = 16;
    localparam int W_REST = ((4 << FRAC_BITS) + 4) / 9;
    localparam int W_AXIS = ((1 << FRAC_BITS) + 4) / 9;
    localparam int W_DIAG = ((1 << FRAC_BITS) + 18) / 36;

    typedef logic signed [POP_W-1:0] t_pop;
    typedef logic signed [FRC_W-1:0] t_frc;
    typedef logic signed [VEL_W-1:0] t_vel;
    typedef logic        [RHO_W-1:0] t_rho;

    // direction and weight of one lane
    typedef struct packed {
        logic signed [1:0]  dx;
        logic signed [1:0]  dy;
        logic [WGT_W-1:0]   wgt;
    } t_dir;

    // node quantities common to all lanes
    typedef struct packed {
        t_vel                   ux;
        t_vel                   uy;
        logic signed [UV_W-1:0] uv;
        logic signed [UF_W-1:0] uf;
        t_rho                   rho;
        t_frc                   fx;
        t_frc                   fy;
    } t_lane_in;

    // node data carried alongside the divider
    typedef struct packed {
        logic [NDIR-1:0][POP_W-1:0] f;
        t_frc                       fx;
        t_frc                       fy;
        t_rho                       rho;
    } t_side;

    // results carried alongside the lanes
    typedef struct packed {
        t_rho rho;
        t_vel ux;
        t_vel uy;
    } t_node_out;

    function automatic t_dir lane_dir(input int k);
        t_dir d;
        d.dx  = (k == 1 || k == 5 || k == 8) ? 2'sd1 :
                (k == 3 || k == 6 || k == 7) ? -2'sd1 : 2'sd0;
        d.dy  = (k == 2 || k == 5 || k == 6) ? 2'sd1 :
                (k == 4 || k == 7 || k == 8) ? -2'sd1 : 2'sd0;
        d.wgt = (k == 0) ? WGT_W'(W_REST) : ((k < 5) ? WGT_W'(W_AXIS) : WGT_W'(W_DIAG));
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/core/d2q9_forced_collision_node.sv]
// ----------------------------------------------------------------------------
// d2q9_forced_collision_node
// D2Q9 BGK collision of one lattice node with body forcing, Q2.16 fixed point.
// ----------------------------------------------------------------------------
// The block takes one lattice node per clock while m_axis does not stall it,
// and returns its nine relaxed populations with density and force-corrected
// velocity. Every node passes the input register, the two 18-stage velocity
// dividers (an entry stage and one quotient bit per stage), three shared
// product stages, the eight-stage direction lanes and the output register.
// The pipeline only halts when its last stage holds a node and the output
// register is still waiting, so s_axis keeps taking words while a result
// waits, until the last stage fills. The user must write relax_rate through
// i_cfg_wen/i_cfg_wdata while the block is idle; the block does not check it.
`default_nettype none

module d2q9_forced_collision_node
    import d2q9fc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wen,
    input  logic [RATE_W-1:0] i_cfg_wdata,    // relax_rate
    // input node words
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // pop_rest, pop_east, pop_north, pop_west, pop_south, pop_ne, pop_nw,
    // pop_sw, pop_se, force_x, force_y, zero padding
    input  logic [IN_W-1:0]   s_axis_tdata,
    // result words
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // post_rest, post_east, post_north, post_west, post_south, post_ne,
    // post_nw, post_sw, post_se, density, vel_x, vel_y, zero padding
    output logic [OUT_W-1:0]  m_axis_tdata
);

    localparam int TOT = 1 + DIV_LAT + 3 + LANE_LAT;

    logic en;
    logic out_load;

    logic [RATE_W-1:0] r_rate;
    logic [TOT-1:0]    r_vld;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [OUT_W-1:0]  n_out_data;

    t_pop                    pop_c [NDIR];
    t_frc                    fx_c;
    t_frc                    fy_c;
    logic signed [SUM_W-1:0] sum_c;
    logic signed [SUM_W-1:0] mx_c;
    logic signed [SUM_W-1:0] my_c;
    t_rho                    rho_c;
    t_side                   side_c;

    t_side                   r_m_side;
    logic signed [NUM_W-1:0] r_m_numx;
    logic signed [NUM_W-1:0] r_m_numy;
    t_side                   r_sd [DIV_LAT];

    t_vel ux_c;
    t_vel uy_c;

    t_side r_u_side;
    t_vel  r_u_ux;
    t_vel  r_u_uy;

    t_side                    r_a_side;
    t_vel                     r_a_ux;
    t_vel                     r_a_uy;
    logic signed [PROD_W-1:0] r_a_uxx;
    logic signed [PROD_W-1:0] r_a_uyy;
    logic signed [PROD_W-1:0] r_a_uxf;
    logic signed [PROD_W-1:0] r_a_uyf;

    logic signed [PROD_W+1:0]   ufs_c;
    t_lane_in                   r_b_node;
    logic [NDIR-1:0][POP_W-1:0] r_b_f;

    t_node_out r_od [LANE_LAT];
    t_pop      post_w [NDIR];

    // flow control: stall only when the last stage cannot drain
    assign out_load      = r_vld[TOT-1] && (!r_out_valid || m_axis_tready);
    assign en            = !r_vld[TOT-1] || !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_W'(RATE_RESET);
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_rate <= i_cfg_wdata;
            end
            if (en) begin
                r_vld <= {r_vld[TOT-2:0], s_axis_tvalid};
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // unpack the input word
    always_comb begin
        for (int k = 0; k < NDIR; k++) begin
            pop_c[k] = s_axis_tdata[POP_W*k +: POP_W];
        end
        fx_c = s_axis_tdata[NDIR*POP_W +: FRC_W];
        fy_c = s_axis_tdata[NDIR*POP_W+FRC_W +: FRC_W];
    end

    // density and momentum
    always_comb begin
        sum_c = '0;
        for (int k = 0; k < NDIR; k++) begin
            sum_c = sum_c + SUM_W'(pop_c[k]);
        end
        mx_c = SUM_W'(pop_c[1]) + SUM_W'(pop_c[5]) + SUM_W'(pop_c[8])
               - SUM_W'(pop_c[3]) - SUM_W'(pop_c[6]) - SUM_W'(pop_c[7]);
        my_c = SUM_W'(pop_c[2]) + SUM_W'(pop_c[5]) + SUM_W'(pop_c[6])
               - SUM_W'(pop_c[4]) - SUM_W'(pop_c[7]) - SUM_W'(pop_c[8]);
        if (sum_c < 0) begin
            rho_c = '0;
        end else if (sum_c > SUM_W'(RHO_MAX)) begin
            rho_c = RHO_W'(RHO_MAX);
        end else begin
            rho_c = sum_c[RHO_W-1:0];
        end
        for (int k = 0; k < NDIR; k++) begin
            side_c.f[k] = pop_c[k];
        end
        side_c.fx  = fx_c;
        side_c.fy  = fy_c;
        side_c.rho = rho_c;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_side <= side_c;
            r_m_numx <= (NUM_W'(mx_c) <<< 1) + NUM_W'(fx_c);
            r_m_numy <= (NUM_W'(my_c) <<< 1) + NUM_W'(fy_c);
        end
    end

    // velocity dividers
    d2q9fc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_m_numx),
        .i_rho (r_m_side.rho),
        .o_vel (ux_c)
    );

    d2q9fc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_m_numy),
        .i_rho (r_m_side.rho),
        .o_vel (uy_c)
    );

    // node data alongside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_m_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // velocity register, then shared products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u_side <= r_sd[DIV_LAT-1];
            r_u_ux   <= ux_c;
            r_u_uy   <= uy_c;

            r_a_side <= r_u_side;
            r_a_ux   <= r_u_ux;
            r_a_uy   <= r_u_uy;
            r_a_uxx  <= PROD_W'(r_u_ux) * PROD_W'(r_u_ux);
            r_a_uyy  <= PROD_W'(r_u_uy) * PROD_W'(r_u_uy);
            r_a_uxf  <= PROD_W'(r_u_ux) * PROD_W'(r_u_side.fx);
            r_a_uyf  <= PROD_W'(r_u_uy) * PROD_W'(r_u_side.fy);
        end
    end

    // u.u and rounded u.F
    assign ufs_c = (PROD_W + 2)'(r_a_uxf) + (PROD_W + 2)'(r_a_uyf)
                   + (PROD_W + 2)'(ONE_Q / 2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_node.ux  <= r_a_ux;
            r_b_node.uy  <= r_a_uy;
            r_b_node.uv  <= UV_W'(r_a_uxx) + UV_W'(r_a_uyy);
            r_b_node.uf  <= ufs_c[PROD_W+1:FRAC_BITS];
            r_b_node.rho <= r_a_side.rho;
            r_b_node.fx  <= r_a_side.fx;
            r_b_node.fy  <= r_a_side.fy;
            r_b_f        <= r_a_side.f;
        end
    end

    // one lane per lattice direction
    for (genvar k = 0; k < NDIR; k++) begin : g_lane
        d2q9fc_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rate (r_rate),
            .i_dir  (lane_dir(k)),
            .i_node (r_b_node),
            .i_pop  (r_b_f[k]),
            .o_post (post_w[k])
        );
    end

    // density and velocity alongside the lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_od[0].rho <= r_b_node.rho;
            r_od[0].ux  <= r_b_node.ux;
            r_od[0].uy  <= r_b_node.uy;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_od[i] <= r_od[i-1];
            end
        end
    end

    // merge lane results into the output word
    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < NDIR; k++) begin
            n_out_data[POP_W*k +: POP_W] = post_w[k];
        end
        n_out_data[NDIR*POP_W +: RHO_W]               = r_od[LANE_LAT-1].rho;
        n_out_data[NDIR*POP_W+RHO_W +: VEL_W]         = r_od[LANE_LAT-1].ux;
        n_out_data[NDIR*POP_W+RHO_W+VEL_W +: VEL_W]   = r_od[LANE_LAT-1].uy;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a full last stage facing a stalled output must hold the input off
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[TOT-1] && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("pipeline advanced into a stalled output");

    // a new result only appears from a valid last stage
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_vld[TOT-1]))
        else $error("result word without a node behind it");

    // zero density gives zero velocity
    a_zero_rho_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_data[NDIR*POP_W +: RHO_W] == '0)) |->
        ((r_out_data[NDIR*POP_W+RHO_W +: VEL_W] == '0) &&
         (r_out_data[NDIR*POP_W+RHO_W+VEL_W +: VEL_W] == '0)))
        else $error("non-zero velocity at zero density");
`endif

endmodule

`default_nettype wire

[rtl/core/d2q9fc_div.sv]
// ----------------------------------------------------------------------------
// d2q9fc_div
// Pipelined restoring divider for one velocity component: rounded
// num / (2 rho), one quotient bit per stage, saturated to the velocity range.
// ----------------------------------------------------------------------------
`default_nettype none

module d2q9fc_div
    import d2q9fc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  t_rho                    i_rho,
    output t_vel                    o_vel
);

    logic signed [NUM_W-1:0] abs_c;
    logic [MAG_W-1:0]        mag_c;
    logic [DIVN_W-1:0]       n_c;
    logic [DIVD_W-1:0]       d_c;

    logic [DIVN_W-1:0] r_n    [0:QBITS];
    logic [DIVD_W-1:0] r_d    [0:QBITS];
    logic [QBITS-1:0]  r_q    [0:QBITS];
    logic              r_neg  [0:QBITS];
    logic              r_zero [0:QBITS];
    logic              r_ovf  [0:QBITS];

    logic [QBITS-1:0] q_c;
    logic [QBITS-1:0] mq_c;
    logic             sat_c;

    // magnitude, rounded numerator and divisor
    assign abs_c = i_num[NUM_W-1] ? -i_num : i_num;
    assign mag_c = abs_c[MAG_W-1:0];
    assign n_c   = DIVN_W'({mag_c, {FRAC_BITS{1'b0}}}) + DIVN_W'(i_rho);
    assign d_c   = {i_rho, 1'b0};

    // entry stage with overflow check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= n_c;
            r_d[0]    <= d_c;
            r_q[0]    <= '0;
            r_neg[0]  <= i_num[NUM_W-1];
            r_zero[0] <= (i_rho == '0);
            r_ovf[0]  <= (n_c >= DIVN_W'({d_c, {QBITS{1'b0}}}));
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 1; s <= QBITS; s++) begin : g_bit
        localparam int B = QBITS - s;
        logic [DIVN_W:0] trial;
        assign trial = {1'b0, r_n[s-1]} - ((DIVN_W + 1)'(r_d[s-1]) << B);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!trial[DIVN_W]) begin
                    r_n[s] <= trial[DIVN_W-1:0];
                    r_q[s] <= r_q[s-1] | (QBITS'(1) << B);
                end else begin
                    r_n[s] <= r_n[s-1];
                    r_q[s] <= r_q[s-1];
                end
                r_d[s]    <= r_d[s-1];
                r_neg[s]  <= r_neg[s-1];
                r_zero[s] <= r_zero[s-1];
                r_ovf[s]  <= r_ovf[s-1];
            end
        end
    end

    // saturate and apply sign
    assign q_c   = r_q[QBITS];
    assign sat_c = r_ovf[QBITS] || (q_c > QBITS'(VEL_LIM));
    assign mq_c  = sat_c ? QBITS'(VEL_LIM) : q_c;

    always_comb begin
        if (r_zero[QBITS]) begin
            o_vel = '0;
        end else if (r_neg[QBITS]) begin
            o_vel = -mq_c;
        end else if (mq_c >= QBITS'(VEL_LIM)) begin
            o_vel = VEL_W'(VEL_MAX);
        end else begin
            o_vel = mq_c;
        end
    end

endmodule

`default_nettype wire

[rtl/core/d2q9fc_lane.sv]
// ----------------------------------------------------------------------------
// d2q9fc_lane
// One direction of the collision: equilibrium, forcing term, half-force
// shift and relaxation, eight register stages deep.
// ----------------------------------------------------------------------------
`default_nettype none

module d2q9fc_lane
    import d2q9fc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RATE_W-1:0] i_rate,
    input  t_dir              i_dir,
    input  t_lane_in          i_node,
    input  t_pop              i_pop,
    output t_pop              o_post
);

    localparam int EU_W   = VEL_W + 2;
    localparam int EF_W   = FRC_W + 2;
    localparam int EFUF_W = UF_W + 1;
    localparam int T3P_W  = UV_W + 3;
    localparam int T3_W   = T3P_W - FRAC_BITS - 1;
    localparam int WRP_W  = WGT_W + RHO_W + 1;
    localparam int WR_W   = WRP_W - FRAC_BITS;
    localparam int SQ_W   = 2 * EU_W;
    localparam int EU3_W  = EU_W + 2;
    localparam int E9_W   = SQ_W + 4;
    localparam int T9_W   = E9_W - FRAC_BITS - 1;
    localparam int POLY_W = T9_W + 2;
    localparam int FP_W   = WR_W + 1 + POLY_W + 1;
    localparam int FEQ_W  = 26;
    localparam int GP_W   = EFUF_W + FEQ_W + 1;
    localparam int G_W    = 30;
    localparam int FS_W   = G_W + 1;
    localparam int D_W    = FS_W + 1;
    localparam int P1_W   = RATE_W + 1 + D_W;
    localparam int P2_W   = RATE_W + 1 + G_W;
    localparam int A_W    = P1_W + 1 - FRAC_BITS;
    localparam int B_W    = P2_W + 1 - FRAC_BITS - 1;
    localparam int PS_W   = A_W + 2;

    // stage 1
    logic signed [EU_W-1:0]   eu_c;
    logic signed [EF_W-1:0]   ef_c;
    logic signed [T3P_W-1:0]  t3p_c;
    logic [WRP_W-1:0]         wrp_c;
    logic signed [EU_W-1:0]   r1_eu;
    logic signed [T3_W-1:0]   r1_t3;
    logic [WR_W-1:0]          r1_wr;
    logic signed [EFUF_W-1:0] r1_efuf;
    t_pop                     r1_f;
    // stage 2
    logic signed [SQ_W-1:0]   r2_sq;
    logic signed [EU3_W-1:0]  r2_eu3;
    logic signed [T3_W-1:0]   r2_t3;
    logic [WR_W-1:0]          r2_wr;
    logic signed [EFUF_W-1:0] r2_efuf;
    t_pop                     r2_f;
    // stage 3
    logic signed [E9_W-1:0]   e9_c;
    logic signed [POLY_W-1:0] r3_poly;
    logic [WR_W-1:0]          r3_wr;
    logic signed [EFUF_W-1:0] r3_efuf;
    t_pop                     r3_f;
    // stage 4
    logic signed [FP_W-1:0]   fp_c;
    logic signed [FEQ_W-1:0]  r4_feq;
    logic signed [EFUF_W-1:0] r4_efuf;
    t_pop                     r4_f;
    // stage 5
    logic signed [GP_W-1:0]   gp_c;
    logic signed [G_W-1:0]    r5_g;
    logic signed [FEQ_W-1:0]  r5_feq;
    t_pop                     r5_f;
    // stage 6
    logic signed [G_W:0]      h_c;
    logic signed [FS_W-1:0]   r6_fs;
    logic signed [G_W-1:0]    r6_g;
    logic signed [FEQ_W-1:0]  r6_feq;
    // stage 7
    logic signed [D_W-1:0]    d_c;
    logic signed [RATE_W:0]   rate_s;
    logic signed [P1_W-1:0]   r7_p1;
    logic signed [P2_W-1:0]   r7_p2;
    logic signed [FS_W-1:0]   r7_fs;
    logic signed [G_W-1:0]    r7_g;
    // stage 8
    logic signed [P1_W:0]     a_t;
    logic signed [P2_W:0]     b_t;
    logic signed [PS_W-1:0]   post_c;
    t_pop                     r8_post;

    // directional projections and rounded weight times density
    always_comb begin
        eu_c = '0;
        ef_c = '0;
        if (i_dir.dx == 2'sd1) begin
            eu_c = eu_c + EU_W'(i_node.ux);
            ef_c = ef_c + EF_W'(i_node.fx);
        end else if (i_dir.dx == -2'sd1) begin
            eu_c = eu_c - EU_W'(i_node.ux);
            ef_c = ef_c - EF_W'(i_node.fx);
        end
        if (i_dir.dy == 2'sd1) begin
            eu_c = eu_c + EU_W'(i_node.uy);
            ef_c = ef_c + EF_W'(i_node.fy);
        end else if (i_dir.dy == -2'sd1) begin
            eu_c = eu_c - EU_W'(i_node.uy);
            ef_c = ef_c - EF_W'(i_node.fy);
        end
    end

    assign t3p_c = T3P_W'(i_node.uv) + (T3P_W'(i_node.uv) <<< 1) + T3P_W'(ONE_Q);
    assign wrp_c = WRP_W'(i_dir.wgt) * WRP_W'(i_node.rho) + WRP_W'(ONE_Q / 2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_eu   <= eu_c;
            r1_t3   <= t3p_c[T3P_W-1:FRAC_BITS+1];
            r1_wr   <= wrp_c[WRP_W-1:FRAC_BITS];
            r1_efuf <= EFUF_W'(ef_c) - EFUF_W'(i_node.uf);
            r1_f    <= i_pop;
        end
    end

    // square of the projection
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sq   <= SQ_W'(r1_eu) * SQ_W'(r1_eu);
            r2_eu3  <= EU3_W'(r1_eu) + (EU3_W'(r1_eu) <<< 1);
            r2_t3   <= r1_t3;
            r2_wr   <= r1_wr;
            r2_efuf <= r1_efuf;
            r2_f    <= r1_f;
        end
    end

    // equilibrium polynomial
    assign e9_c = (E9_W'(r2_sq) <<< 3) + E9_W'(r2_sq) + E9_W'(ONE_Q);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_poly <= POLY_W'(ONE_Q) + POLY_W'(r2_eu3)
                       + POLY_W'(signed'(e9_c[E9_W-1:FRAC_BITS+1])) - POLY_W'(r2_t3);
            r3_wr   <= r2_wr;
            r3_efuf <= r2_efuf;
            r3_f    <= r2_f;
        end
    end

    // equilibrium
    assign fp_c = FP_W'(signed'({1'b0, r3_wr})) * FP_W'(r3_poly) + FP_W'(ONE_Q / 2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_feq  <= fp_c[FRAC_BITS+FEQ_W-1:FRAC_BITS];
            r4_efuf <= r3_efuf;
            r4_f    <= r3_f;
        end
    end

    // forcing term
    assign gp_c = GP_W'(r4_efuf) * GP_W'(r4_feq) + GP_W'(ONE_Q / 2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_g   <= gp_c[FRAC_BITS+G_W-1:FRAC_BITS];
            r5_feq <= r4_feq;
            r5_f   <= r4_f;
        end
    end

    // half-force shift
    assign h_c = (G_W + 1)'(r5_g) + (G_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_fs  <= FS_W'(r5_f) - FS_W'(signed'(h_c[G_W:1]));
            r6_g   <= r5_g;
            r6_feq <= r5_feq;
        end
    end

    // relaxation products
    assign d_c    = D_W'(r6_feq) - D_W'(r6_fs);
    assign rate_s = signed'({1'b0, i_rate});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_p1 <= P1_W'(rate_s) * P1_W'(d_c);
            r7_p2 <= P2_W'(rate_s) * P2_W'(r6_g);
            r7_fs <= r6_fs;
            r7_g  <= r6_g;
        end
    end

    // sum and saturate
    assign a_t = (P1_W + 1)'(r7_p1) + (P1_W + 1)'(ONE_Q / 2);
    assign b_t = (P2_W + 1)'(r7_p2) + (P2_W + 1)'(ONE_Q);
    assign post_c = PS_W'(r7_fs) + PS_W'(signed'(a_t[P1_W:FRAC_BITS])) + PS_W'(r7_g)
                    - PS_W'(signed'(b_t[P2_W:FRAC_BITS+1]));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (post_c > PS_W'(POP_MAX)) begin
                r8_post <= POP_W'(POP_MAX);
            end else if (post_c < PS_W'(POP_MIN)) begin
                r8_post <= POP_W'(POP_MIN);
            end else begin
                r8_post <= post_c[POP_W-1:0];
            end
        end
    end

    assign o_post = r8_post;

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the forced D2Q9 collision node: random and directed
// node words under random stalls, checked against a local fixed-point model.
// ----------------------------------------------------------------------------
`default_nettype none

import d2q9fc_pkg::*;

// expected result words in order of acceptance
class collision_board;
    logic [OUT_W-1:0] pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note_node(logic [OUT_W-1:0] w);
        pending.push_back(w);
    endfunction

    function void check_word(logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] exp_w;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        for (int k = 0; k < 9; k++)
            if (exp_w[k*18 +: 18] !== got[k*18 +: 18]) begin
                $display("%0t: post %0d expected %h actual %h", $time, k,
                         exp_w[k*18 +: 18], got[k*18 +: 18]);
                errors++;
            end
        if (exp_w[162 +: 17] !== got[162 +: 17]) begin
            $display("%0t: density expected %h actual %h", $time,
                     exp_w[162 +: 17], got[162 +: 17]);
            errors++;
        end
        if (exp_w[179 +: 17] !== got[179 +: 17]) begin
            $display("%0t: vel_x expected %h actual %h", $time,
                     exp_w[179 +: 17], got[179 +: 17]);
            errors++;
        end
        if (exp_w[196 +: 17] !== got[196 +: 17]) begin
            $display("%0t: vel_y expected %h actual %h", $time,
                     exp_w[196 +: 17], got[196 +: 17]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_wen = 0;
    logic [RATE_W-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;

    collision_board board = new();
    longint rate_q = RATE_RESET;
    int cycles = 0;
    int hold_off = 0;
    int sink_wait = 0;
    int sink_draw = 0;
    bit sink_busy_mode = 0;

    localparam int XD[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int YD[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

    d2q9_forced_collision_node i_dut (.*);

    always #5 i_clk = ~i_clk;

    // arithmetic shift with rounding to nearest, ties up
    function automatic longint round_sh(longint x, int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint node_vel(longint num2, longint rho);
        longint mag, den, q;
        mag = num2 < 0 ? -num2 : num2;
        den = rho * 2;
        q = ((mag << FRAC_BITS) + den / 2) / den;
        if (q > 65536) q = 65536;
        return clip(num2 < 0 ? -q : q, -65536, 65535);
    endfunction

    // collision of one node word into its result word
    function automatic logic [OUT_W-1:0] collide_node(logic [IN_W-1:0] w);
        longint f[9];
        longint fx, fy, sum, mx, my, rho, ux, uy, uv, uf;
        longint eu, poly, wr, wgt, feq, ef, g, fs, post;
        logic [OUT_W-1:0] r;
        sum = 0; mx = 0; my = 0; ux = 0; uy = 0; r = '0;
        for (int k = 0; k < 9; k++) begin
            f[k] = longint'($signed(w[k*18 +: 18]));
            sum += f[k];
            mx += XD[k] * f[k];
            my += YD[k] * f[k];
        end
        fx = longint'($signed(w[162 +: 17]));
        fy = longint'($signed(w[179 +: 17]));
        rho = clip(sum, 0, 131071);
        if (rho > 0) begin
            ux = node_vel(2 * mx + fx, rho);
            uy = node_vel(2 * my + fy, rho);
        end
        uv = ux * ux + uy * uy;
        uf = round_sh(ux * fx + uy * fy, FRAC_BITS);
        for (int k = 0; k < 9; k++) begin
            wgt = k == 0 ? W_REST : (k < 5 ? W_AXIS : W_DIAG);
            eu = XD[k] * ux + YD[k] * uy;
            poly = ONE_Q + 3 * eu + round_sh(9 * eu * eu, FRAC_BITS + 1)
                   - round_sh(3 * uv, FRAC_BITS + 1);
            wr = round_sh(wgt * rho, FRAC_BITS);
            feq = round_sh(wr * poly, FRAC_BITS);
            ef = XD[k] * fx + YD[k] * fy;
            g = round_sh((ef - uf) * feq, FRAC_BITS);
            fs = f[k] - round_sh(g, 1);
            post = fs + round_sh(rate_q * (feq - fs), FRAC_BITS)
                   + g - round_sh(rate_q * g, FRAC_BITS + 1);
            r[k*18 +: 18] = 18'(clip(post, -131072, 131071));
        end
        r[162 +: 17] = 17'(rho);
        r[179 +: 17] = 17'(ux);
        r[196 +: 17] = 17'(uy);
        return r;
    endfunction

    function automatic logic [IN_W-1:0] rand_node(int kind);
        logic [IN_W-1:0] w;
        w = '0;
        for (int k = 0; k < 9; k++)
            case (kind)
                0: w[k*18 +: 18] = 18'($urandom);
                1: w[k*18 +: 18] = 18'($urandom_range(0, 16000));
                default: w[k*18 +: 18] = 18'($urandom_range(0, 1500));
            endcase
        if (kind == 0 || $urandom_range(0, 3) == 0) begin
            w[162 +: 17] = 17'($urandom);
            w[179 +: 17] = 17'($urandom);
        end else begin
            w[162 +: 17] = 17'(int'($urandom_range(0, 800)) - 400);
            w[179 +: 17] = 17'(int'($urandom_range(0, 800)) - 400);
        end
        return w;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: a drawn wait after each word, with one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_axis_tready <= (sink_wait == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (sink_busy_mode)
                sink_draw = $urandom_range(8, 15);
            else
                sink_draw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
            sink_wait <= sink_draw;
            m_axis_tready <= (sink_draw == 0);
        end else begin
            m_axis_tready <= 1;
        end
    end

    task automatic send_node(logic [IN_W-1:0] w, int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_node(collide_node(w));
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [RATE_W-1:0] v);
        drain();
        i_cfg_wen <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen <= 0;
        rate_q = v;
        @(posedge i_clk);
    endtask

    initial begin
        logic [IN_W-1:0] w;
        logic [RATE_W-1:0] rates[5];
        rates = '{17'd0, 17'd1, 17'h1FFFF, 17'd65536, 17'd81920};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, zero and negative density, saturated flows
        send_node('0, 0);
        w = '0; for (int k = 0; k < 9; k++) w[k*18 +: 18] = 18'h1FFFF;
        send_node(w, 0);
        w[162 +: 17] = 17'h0FFFF; w[179 +: 17] = 17'h10000;
        send_node(w, 1);
        w = '0; for (int k = 0; k < 9; k++) w[k*18 +: 18] = 18'h20000;
        send_node(w, 0);
        w = '0; w[1*18 +: 18] = 18'h1FFFF; w[5*18 +: 18] = 18'h1FFFF;
        send_node(w, 0);
        w = '0; w[3*18 +: 18] = 18'd10; w[162 +: 17] = 17'h10000;
        send_node(w, 0);
        w = '0; w[0 +: 18] = 18'd65536; w[179 +: 17] = 17'h0FFFF;
        send_node(w, 0);
        w = '0; w[2*18 +: 18] = 18'd1;
        send_node(w, 0);
        for (int k = 0; k < 9; k++) begin
            w = '0; w[k*18 +: 18] = 18'd7282; w[0 +: 18] = 18'd29127;
            send_node(w, $urandom_range(0, 2));
        end

        // random phases over several rates, extremes among them
        for (int p = 0; p < 6; p++) begin
            if (p > 0) write_rate(p < 5 ? rates[p] : 17'($urandom_range(1, 131071)));
            for (int i = 0; i < 260; i++) begin
                if (p == 2 && i == 50) begin
                    hold_off = 120;
                    for (int j = 0; j < 60; j++) send_node(rand_node(1), 0);
                end
                if (p == 3 && i == 100) drain();
                sink_busy_mode = (p == 4 && i < 80);
                send_node(rand_node($urandom_range(0, 4)),
                          ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0);
            end
        end
        sink_busy_mode = 0;
        drain();
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

`default_nettype wire

[files.f]
rtl/core/d2q9fc_pkg.sv
rtl/core/d2q9fc_div.sv
rtl/core/d2q9fc_lane.sv
rtl/core/d2q9_forced_collision_node.sv
verif/tb_top.sv
